// File: design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, defaults and saturation helpers for the tridiagonal solver.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_ROWS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] coef_sub;
        logic signed [31:0] coef_diag;
        logic signed [31:0] coef_super;
        logic signed [31:0] rhs;
        logic               last_row;
        logic        [9:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic        [9:0]  value_index;
        logic               solution_ready;
        logic               singular;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

endpackage

// File: design/tts_mul.sv
// ----------------------------------------------------------------------------
// tts_mul
// Two-stage fixed-point multiplier: product, then round half up and saturate.
// ----------------------------------------------------------------------------
module tts_mul #(
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_res
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_res;
    logic signed [63:0] rounded;
    logic signed [63:0] shifted;
    logic signed [31:0] n_res;

    always_comb begin
        rounded = r_prod + HALF;
        shifted = rounded >>> FRAC_BITS;
        if (shifted > 64'sh0000_0000_7FFF_FFFF) begin
            n_res = tts_pkg::SAT_MAX;
        end else if (shifted < -64'sh0000_0000_8000_0000) begin
            n_res = tts_pkg::SAT_MIN;
        end else begin
            n_res = shifted[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
        r_res  <= n_res;
    end

    assign o_res = r_res;

endmodule

// File: design/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module tts_div #(
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tts_pkg::t_div_req i_req,
    output tts_pkg::t_div_rsp o_rsp
);

    localparam int NW = 32 + FRAC_BITS;

    logic [32:0]        num_s, den_s, num_m, den_m;
    logic [NW-1:0]      num_sh;
    logic [FRAC_BITS-1:0] hi;
    logic               ovf;
    logic [32:0]        rs;
    logic               ge;
    logic [31:0]        qn;
    logic signed [31:0] fin;

    logic               r_busy, r_done, r_neg;
    logic [4:0]         r_cnt;
    logic [31:0]        r_rem, r_lo, r_q, r_dm;
    logic signed [31:0] r_quo;

    always_comb begin
        num_s  = {i_req.num[31], i_req.num};
        den_s  = {i_req.den[31], i_req.den};
        num_m  = i_req.num[31] ? (~num_s + 33'd1) : num_s;
        den_m  = i_req.den[31] ? (~den_s + 33'd1) : den_s;
        num_sh = {num_m[31:0], {FRAC_BITS{1'b0}}};
        hi     = num_sh[NW-1:32];
        ovf    = {{(33 - FRAC_BITS){1'b0}}, hi} >= {1'b0, den_m[31:0]};
        rs     = {r_rem, r_lo[31]};
        ge     = rs >= {1'b0, r_dm};
        qn     = {r_q[30:0], ge};
        if (r_neg) begin
            fin = (qn > 32'h8000_0000) ? tts_pkg::SAT_MIN : $signed(~qn + 32'd1);
        end else begin
            fin = qn[31] ? tts_pkg::SAT_MAX : $signed(qn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                if (den_m[31:0] == 32'd0 || ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= ge ? 32'(rs - {1'b0, r_dm}) : rs[31:0];
            r_lo  <= {r_lo[30:0], 1'b0};
            r_q   <= qn;
            if (r_cnt == 5'd31) begin
                r_quo <= fin;
            end
        end else if (i_req.start) begin
            r_neg <= i_req.num[31] ^ i_req.den[31];
            r_dm  <= den_m[31:0];
            r_rem <= 32'(hi);
            r_lo  <= num_sh[31:0];
            r_q   <= 32'd0;
            if (den_m[31:0] == 32'd0) begin
                r_quo <= 32'sd0;
            end else if (ovf) begin
                r_quo <= (i_req.num[31] ^ i_req.den[31]) ? tts_pkg::SAT_MIN
                                                          : tts_pkg::SAT_MAX;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: design/tridiagonal_thomas_solver.sv
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver
// Thomas-sweep solver for a tridiagonal system in signed fixed point.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) takes load and read
// items. A load item carries one row; rows arrive in order, and the row
// flagged last_row triggers back substitution into the solution store.
// A read item returns one solution entry on the output channel
// (o_out_valid / i_out_stall / o_out_data) with the solve and singular flags.
// All work goes through one multiplier (two-stage) and one iterative divider
// retiring one quotient bit per cycle.
// Load item: fetch previous P and Q, form denominator and numerator, then
// divide for P (skipped on the last row) and Q; the last row then runs back
// substitution over every stored row. Read item: S_READ registers the
// result once the output register is free, then returns to idle.
// o_in_stall is high whenever the sequencer is busy. The output register
// holds a result until taken; a read waiting on a stalled receiver holds
// the sequencer.
// Reset clears row count and flags; the P, Q and solution stores are not
// cleared and read as garbage until written.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tts_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tts_pkg::t_out_item o_out_data
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_READ    = 12'b0000_0000_0010,
        S_L_FETCH = 12'b0000_0000_0100,
        S_L_MULQ  = 12'b0000_0000_1000,
        S_L_DEN   = 12'b0000_0001_0000,
        S_L_NUM   = 12'b0000_0010_0000,
        S_L_DIVP  = 12'b0000_0100_0000,
        S_L_QSTRT = 12'b0000_1000_0000,
        S_L_DIVQ  = 12'b0001_0000_0000,
        S_BS_INIT = 12'b0010_0000_0000,
        S_BS_TOP  = 12'b0100_0000_0000,
        S_BS_FETCH = 12'b1000_0000_0000
    } t_state;

    // back-substitution multiply wait states share codes via sub-phase counter
    t_state             r_state;
    logic [1:0]         r_bs_ph;
    logic [CW-1:0]      r_rc;
    logic               r_solved, r_sing;
    logic signed [31:0] r_a, r_b, r_c, r_d, r_den, r_num, r_u;
    logic               r_last;
    logic [AW-1:0]      r_row, r_bs_idx;
    logic signed [31:0] r_p_rd, r_q_rd, r_s_rd;
    logic [9:0]         r_idx;
    logic               r_idx_ok;
    logic               r_ov;
    tts_pkg::t_out_item r_out;

    logic signed [31:0] mem_p [MAX_ROWS];
    logic signed [31:0] mem_q [MAX_ROWS];
    logic signed [31:0] mem_s [MAX_ROWS];

    logic               in_acc;
    logic               rd_en;
    logic [CW-1:0]      rc_m1;
    logic [AW-1:0]      rd_addr, sol_addr;
    logic [AW+9:0]      idx_ext;
    logic               p_we, q_we, s_we;
    logic signed [31:0] p_wd, u_next;
    logic signed [31:0] mul_a, mul_b, mul_res;
    tts_pkg::t_div_req  div_req;
    tts_pkg::t_div_rsp  div_rsp;
    logic               bs_step;

    tts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        rc_m1    = CW'(r_rc - CW'(1)) & {CW{1'b1}};
        idx_ext  = {{AW{1'b0}}, i_in_data.read_index};
        sol_addr = idx_ext[AW-1:0];
        rd_en    = (r_state == S_IDLE) || (r_state == S_BS_INIT) ||
                   (r_state == S_BS_FETCH && r_bs_ph == 2'd0);
        rd_addr  = (r_state == S_IDLE) ? rc_m1[AW-1:0] : r_bs_idx;

        // first row of a system has no previous P, Q
        mul_a = (r_state == S_BS_FETCH) ? r_p_rd : r_a;
        mul_b = (r_state == S_L_FETCH) ? ((r_row == '0) ? 32'sd0 : r_p_rd) :
                (r_state == S_L_MULQ)  ? ((r_row == '0) ? 32'sd0 : r_q_rd) : r_u;

        div_req.start = ((r_state == S_L_NUM) && !r_last) || (r_state == S_L_QSTRT);
        div_req.num   = (r_state == S_L_NUM) ? r_c : r_num;
        div_req.den   = r_den;

        p_we = ((r_state == S_L_NUM) && r_last) || ((r_state == S_L_DIVP) && div_rsp.done);
        p_wd = (r_state == S_L_NUM) ? 32'sd0 : div_rsp.quo;
        q_we = (r_state == S_L_DIVQ) && div_rsp.done;

        bs_step = (r_state == S_BS_TOP) || ((r_state == S_BS_FETCH) && r_bs_ph == 2'd3);
        u_next  = (r_state == S_BS_TOP) ? r_q_rd : tts_pkg::sat_add(mul_res, r_q_rd);
        s_we    = bs_step;
    end

    always_ff @(posedge i_clk) begin
        if (p_we) mem_p[r_row] <= p_wd;
        if (q_we) mem_q[r_row] <= div_rsp.quo;
        if (s_we) mem_s[r_bs_idx] <= u_next;
        if (rd_en) begin
            r_p_rd <= mem_p[rd_addr];
            r_q_rd <= mem_q[rd_addr];
        end
        if (r_state == S_IDLE) r_s_rd <= mem_s[sol_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bs_ph  <= 2'd0;
            r_rc     <= '0;
            r_solved <= 1'b0;
            r_sing   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_READ && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state) inside
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.kind) begin
                            r_idx    <= i_in_data.read_index;
                            r_idx_ok <= {22'd0, i_in_data.read_index} < 32'(MAX_ROWS);
                            r_state  <= S_READ;
                        end else begin
                            r_solved <= 1'b0;
                            if (r_rc == '0) r_sing <= 1'b0;
                            r_a    <= (r_rc == '0) ? 32'sd0 : i_in_data.coef_sub;
                            r_b    <= i_in_data.coef_diag;
                            r_c    <= i_in_data.coef_super;
                            r_d    <= i_in_data.rhs;
                            r_last <= i_in_data.last_row;
                            r_row  <= r_rc[AW-1:0];
                            if (r_rc == CW'(MAX_ROWS)) begin
                                if (i_in_data.last_row) begin
                                    r_bs_idx <= AW'(MAX_ROWS - 1);
                                    r_state  <= S_BS_INIT;
                                end
                            end else begin
                                r_state <= S_L_FETCH;
                            end
                        end
                    end
                end
                S_READ: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out.solution_value <= r_idx_ok ? r_s_rd : 32'sd0;
                        r_out.value_index    <= r_idx;
                        r_out.solution_ready <= r_solved;
                        r_out.singular       <= r_sing;
                        r_state              <= S_IDLE;
                    end
                end
                S_L_FETCH: r_state <= S_L_MULQ;
                S_L_MULQ:  r_state <= S_L_DEN;
                S_L_DEN: begin
                    r_den   <= tts_pkg::sat_sub(r_b, mul_res);
                    r_state <= S_L_NUM;
                end
                S_L_NUM: begin
                    r_num   <= tts_pkg::sat_sub(mul_res, r_d);
                    r_state <= r_last ? S_L_QSTRT : S_L_DIVP;
                end
                S_L_DIVP: begin
                    if (div_rsp.done) begin
                        if (r_den == 32'sd0) r_sing <= 1'b1;
                        r_state <= S_L_QSTRT;
                    end
                end
                S_L_QSTRT: r_state <= S_L_DIVQ;
                S_L_DIVQ: begin
                    if (div_rsp.done) begin
                        if (r_den == 32'sd0) r_sing <= 1'b1;
                        r_rc <= r_rc + CW'(1);
                        if (r_last) begin
                            r_bs_idx <= r_row;
                            r_state  <= S_BS_INIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_BS_INIT: r_state <= S_BS_TOP;
                S_BS_TOP, S_BS_FETCH: begin
                    if (r_state == S_BS_FETCH && r_bs_ph != 2'd3) begin
                        r_bs_ph <= r_bs_ph + 2'd1;
                    end
                    if (bs_step) begin
                        r_u     <= u_next;
                        r_bs_ph <= 2'd0;
                        if (r_bs_idx == '0) begin
                            r_solved <= 1'b1;
                            r_rc     <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_bs_idx <= r_bs_idx - AW'(1);
                            r_state  <= S_BS_FETCH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
